// File: sv/des_pkg.sv
// Package for the drive enable sequencer: field widths, codes, state enum,
// register defaults and the structs shared by the sequencer modules.
// No dependencies.
package des_pkg;

  localparam int unsigned PedalW = 15;
  localparam int unsigned DurW   = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned DashW  = 2;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 88;
  localparam int unsigned OutDataW = 24;

  localparam logic [PedalW-1:0] BrakeThresholdRst = PedalW'(2560);
  localparam logic [PedalW-1:0] MismatchLimitRst  = PedalW'(2560);
  localparam logic [DurW-1:0]   SpeakerDurRst     = DurW'(2000);

  localparam logic [CfgIdxW-1:0] RegBrakeThreshold = 2'd0;
  localparam logic [CfgIdxW-1:0] RegMismatchLimit  = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSpeakerDur     = 2'd2;

  localparam logic [CmdW-1:0] CmdInit     = 3'd1;
  localparam logic [CmdW-1:0] CmdHvOn     = 3'd2;
  localparam logic [CmdW-1:0] CmdReady    = 3'd3;
  localparam logic [CmdW-1:0] CmdRunError = 3'd4;
  localparam logic [CmdW-1:0] CmdShutdown = 3'd5;

  localparam logic [DashW-1:0] DashHv     = 2'd1;
  localparam logic [DashW-1:0] DashMotors = 2'd2;

  typedef enum logic [2:0] {
    ModeIdle      = 3'd0,
    ModeWaitHv    = 3'd1,
    ModeReqHv     = 3'd2,
    ModeWaitMotor = 3'd3,
    ModeReqMotor  = 3'd4,
    ModeRunning   = 3'd5,
    ModeErr       = 3'd6,
    ModeErrCoast  = 3'd7
  } mode_e;

  typedef struct packed {
    logic [PedalW-1:0] brake_threshold;
    logic [PedalW-1:0] mismatch_limit;
    logic [DurW-1:0]   speaker_duration;
  } des_cfg_t;

  typedef struct packed {
    logic [TimeW-1:0]  now_ms;
    logic [DashW-1:0]  dash_request;
    logic [CmdW-1:0]   command;
    logic [PedalW-1:0] brake_pos;
    logic [PedalW-1:0] accel_pos_b;
    logic [PedalW-1:0] accel_pos_a;
  } des_in_t;

  typedef struct packed {
    logic [PedalW-1:0] torque_request;
    logic              brake_light;
    logic              speaker_on;
    logic              drive_ready;
    logic [2:0]        status;
  } des_res_t;

endpackage

// File: sv/des_cfg.sv
// Configuration register file of the drive enable sequencer.
// Depends on des_pkg.
module des_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [des_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [des_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output des_pkg::des_cfg_t             cfg_o
);
  import des_pkg::*;

  des_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.brake_threshold  <= BrakeThresholdRst;
      cfg_q.mismatch_limit   <= MismatchLimitRst;
      cfg_q.speaker_duration <= SpeakerDurRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegBrakeThreshold: cfg_q.brake_threshold  <= cfg_wdata_i[PedalW-1:0];
        RegMismatchLimit:  cfg_q.mismatch_limit   <= cfg_wdata_i[PedalW-1:0];
        RegSpeakerDur:     cfg_q.speaker_duration <= cfg_wdata_i[DurW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/des_step.sv
// Next-state and result logic for one tick of the drive enable sequencer.
// Purely combinational; depends on des_pkg.
module des_step (
  input  des_pkg::des_in_t              in_i,
  input  des_pkg::des_cfg_t             cfg_i,
  input  des_pkg::mode_e                mode_i,
  input  logic [des_pkg::TimeW-1:0]     run_start_i,
  output des_pkg::mode_e                mode_o,
  output logic [des_pkg::TimeW-1:0]     run_start_o,
  output des_pkg::des_res_t             res_o
);
  import des_pkg::*;

  logic [PedalW-1:0] diff;
  logic              bad;
  logic              brake_on;
  logic              running;
  logic [TimeW-1:0]  elapsed;

  assign diff = (in_i.accel_pos_a > in_i.accel_pos_b) ?
                (in_i.accel_pos_a - in_i.accel_pos_b) :
                (in_i.accel_pos_b - in_i.accel_pos_a);
  assign bad      = diff > cfg_i.mismatch_limit;
  assign brake_on = in_i.brake_pos > cfg_i.brake_threshold;

  always_comb begin
    mode_o      = mode_i;
    run_start_o = run_start_i;
    case (mode_i)
      ModeIdle: begin
        if (in_i.command == CmdInit) mode_o = ModeWaitHv;
      end
      ModeWaitHv: begin
        if (in_i.dash_request == DashHv) mode_o = ModeReqHv;
      end
      ModeReqHv: begin
        if (in_i.command == CmdHvOn) mode_o = ModeWaitMotor;
      end
      ModeWaitMotor: begin
        if (in_i.dash_request == DashMotors) mode_o = ModeReqMotor;
      end
      ModeReqMotor: begin
        if (in_i.command == CmdReady && brake_on) begin
          mode_o      = ModeRunning;
          run_start_o = in_i.now_ms;
        end
      end
      ModeRunning: begin
        if (in_i.command == CmdRunError) mode_o = ModeErrCoast;
      end
      default: ;
    endcase
    // overrides; wait motor is exempt
    if (mode_i inside {ModeWaitHv, ModeReqHv, ModeReqMotor, ModeRunning}) begin
      run_start_o = run_start_i;
      if (in_i.command == CmdShutdown) begin
        mode_o = ModeIdle;
      end else if (bad) begin
        mode_o = ModeErr;
      end else if (mode_i == ModeReqMotor && mode_o == ModeRunning) begin
        run_start_o = in_i.now_ms;
      end
    end
  end

  assign running = mode_o == ModeRunning;
  assign elapsed = in_i.now_ms - run_start_o;

  assign res_o.status         = mode_o;
  assign res_o.drive_ready    = running;
  assign res_o.speaker_on     = running && (elapsed <= TimeW'(cfg_i.speaker_duration));
  assign res_o.brake_light    = brake_on;
  assign res_o.torque_request = (running && !bad) ? in_i.accel_pos_a : '0;

endmodule

// File: sv/drive_enable_sequencer_core.sv
// Drive enable sequencer: input register, one pass of step logic, result
// register. An accepted word moves from the input register to the result
// register, which raises m_tvalid; one word per cycle sustained while
// m_tready is high, the mode register updating as the word moves. Reset
// (rst_ni low, async) empties both registers, sets mode to idle, run start
// time to zero and the config registers to their defaults.
// Depends on des_pkg, des_cfg, des_step.
module drive_enable_sequencer_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [des_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [des_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  // accel_pos_a[14:0], accel_pos_b[29:15], brake_pos[44:30], command[47:45],
  // dash_request[49:48], now_ms[81:50], zero[87:82]
  input  logic [des_pkg::InDataW-1:0]   s_tdata_i,
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  // status[2:0], drive_ready[3], speaker_on[4], brake_light[5],
  // torque_request[20:6], zero[23:21]
  output logic [des_pkg::OutDataW-1:0]  m_tdata_o
);
  import des_pkg::*;

  localparam int unsigned ResW = $bits(des_res_t);
  localparam int unsigned InW  = $bits(des_in_t);

  des_cfg_t         cfg;
  des_in_t          in_q;
  logic             in_valid_q;
  des_res_t         res_d, res_q;
  logic             out_valid_q;
  mode_e            mode_q, mode_d;
  logic [TimeW-1:0] run_start_q, run_start_d;
  logic             advance;

  des_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  des_step u_step (
    .in_i       (in_q),
    .cfg_i      (cfg),
    .mode_i     (mode_q),
    .run_start_i(run_start_q),
    .mode_o     (mode_d),
    .run_start_o(run_start_d),
    .res_o      (res_d)
  );

  assign advance    = in_valid_q && (!out_valid_q || m_tready_i);
  assign s_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      mode_q      <= ModeIdle;
      run_start_q <= '0;
    end else begin
      if (s_tready_o) in_valid_q <= s_tvalid_i;
      if (advance) begin
        out_valid_q <= 1'b1;
        mode_q      <= mode_d;
        run_start_q <= run_start_d;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tready_o && s_tvalid_i) in_q <= des_in_t'(s_tdata_i[InW-1:0]);
    if (advance) res_q <= res_d;
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {{(OutDataW-ResW){1'b0}}, res_q};

endmodule
